### rtl/cms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants of the count-min sketch
// Table geometry, hash constants, the command code and the structure of one
// row operation passed from the front end to the back end.
// ----------------------------------------------------------------------------
package cms_pkg;

	localparam int ROWS       = 4;
	localparam int COLS       = 256;
	localparam int COUNT_BITS = 32;
	localparam int ROW_W      = 2;
	localparam int COL_W      = 8;
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int DEPTH      = ROWS * COLS;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;

	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;
	localparam logic [63:0] STRIDE = 64'h00000000cafef00d;
	localparam int SH1 = 30;
	localparam int SH2 = 27;
	localparam int SH3 = 31;

	localparam logic [1:0] REG_COLS = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;

	typedef enum logic {CMD_ADD = 1'b0, CMD_EST = 1'b1} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic signed [15:0] delta;
		logic              last;
	} op_t;

	typedef enum logic [2:0] {F_IDLE, F_MUL1, F_MUL2, F_MOD, F_PUSH} front_state_t;
	typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} back_state_t;

endpackage
`default_nettype wire

### rtl/cms_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_front: hashing front end
// Takes one item, hashes its key once per row and reduces the hash modulo the
// column count, then queues one row operation per row.
// ----------------------------------------------------------------------------
module cms_front import cms_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        command,
	input  wire logic [63:0] key,
	input  wire logic signed [15:0] delta,
	input  wire logic [8:0]  ncols,
	input  wire logic [2:0]  nrows,
	output logic             busy,
	output logic             q_push,
	output op_t              q_op,
	input  wire logic        q_full
);

	front_state_t state_q, state_nx;
	cmd_t               cmd_q;
	logic [63:0]        key_q;
	logic signed [15:0] delta_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [63:0]        work_q;
	logic [63:0]        acc_q;
	logic [3:0]         step_q;
	logic [8:0]         rem_q;

	logic [63:0]      mix_a, mix_c, mul_p, acc_nx, hash_v, row_off;
	logic [31:0]      mul_x, mul_y;
	logic [8:0]       rem_nx;
	logic [ROW_W-1:0] row_inc;
	logic             last;

	assign last    = ({1'b0, row_q} == (nrows - 3'd1));
	assign row_inc = row_q + 1'b1;
	assign row_off = {62'd0, row_inc} * STRIDE;

	// Three 32x32 partial products give the low 64 bits of the product.
	always_comb begin
		if (state_q == F_MUL1) begin
			mix_a = work_q ^ (work_q >> SH1);
			mix_c = MIX1;
		end else begin
			mix_a = work_q ^ (work_q >> SH2);
			mix_c = MIX2;
		end
		case (step_q)
			4'd0: begin
				mul_x = mix_a[31:0];
				mul_y = mix_c[31:0];
			end
			4'd1: begin
				mul_x = mix_a[63:32];
				mul_y = mix_c[31:0];
			end
			default: begin
				mul_x = mix_a[31:0];
				mul_y = mix_c[63:32];
			end
		endcase
	end

	assign mul_p  = {32'd0, mul_x} * {32'd0, mul_y};
	assign acc_nx = (step_q == 4'd0) ? mul_p : acc_q + {mul_p[31:0], 32'd0};
	assign hash_v = acc_nx ^ (acc_nx >> SH3);

	// Four restoring steps of the modulo per cycle, most significant bit first.
	always_comb begin
		logic [8:0] r;
		r = rem_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[7:0], work_q[63-i]};
			if (r >= ncols) begin
				r = r - ncols;
			end
		end
		rem_nx = r;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			F_IDLE: begin
				if (start) state_nx = F_MUL1;
			end
			F_MUL1: begin
				if (step_q == 4'd2) state_nx = F_MUL2;
			end
			F_MUL2: begin
				if (step_q == 4'd2) state_nx = F_MOD;
			end
			F_MOD: begin
				if (step_q == 4'd15) state_nx = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) state_nx = last ? F_IDLE : F_MUL1;
			end
			default: state_nx = F_IDLE;
		endcase
	end

	always_comb begin
		busy         = (state_q != F_IDLE);
		q_push       = (state_q == F_PUSH) && !q_full;
		q_op.cmd     = cmd_q;
		q_op.row     = row_q;
		q_op.col     = col_q;
		q_op.delta   = delta_q;
		q_op.last    = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (start) begin
					cmd_q   <= cmd_t'(command);
					key_q   <= key;
					delta_q <= delta;
					row_q   <= '0;
					work_q  <= key + GOLDEN;
					step_q  <= '0;
				end
			end
			F_MUL1: begin
				acc_q  <= acc_nx;
				step_q <= (step_q == 4'd2) ? 4'd0 : step_q + 4'd1;
				if (step_q == 4'd2) work_q <= acc_nx;
			end
			F_MUL2: begin
				acc_q  <= acc_nx;
				step_q <= (step_q == 4'd2) ? 4'd0 : step_q + 4'd1;
				if (step_q == 4'd2) begin
					work_q <= hash_v;
					rem_q  <= '0;
				end
			end
			F_MOD: begin
				rem_q  <= rem_nx;
				work_q <= {work_q[59:0], 4'd0};
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) col_q <= rem_nx[COL_W-1:0];
			end
			F_PUSH: begin
				if (!q_full && !last) begin
					row_q  <= row_inc;
					work_q <= key_q + row_off + GOLDEN;
					step_q <= '0;
				end
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

endmodule
`default_nettype wire

### rtl/cms_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_queue: row operation queue
// A small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module cms_queue import cms_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  op_t       push_op,
	output logic      full,
	input  wire logic pop,
	output op_t       pop_op,
	output logic      empty
);

	op_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_op  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_op;
	end

endmodule
`default_nettype wire

### rtl/cms_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_back: counter table back end
// Holds the counter memory, clears it after reset, and carries out one row
// operation at a time: a saturating add or a step of the running minimum.
// ----------------------------------------------------------------------------
module cms_back import cms_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  op_t       q_op,
	output logic      q_pop,
	input  wire logic res_pop,
	output logic      res_valid,
	output logic [31:0] res_value,
	output logic      clearing
);

	back_state_t state_q, state_nx;
	logic [COUNT_BITS-1:0] mem [DEPTH];
	logic [COUNT_BITS-1:0] rdata_q;
	logic [ADDR_W-1:0]     clr_q;
	op_t                   op_q;
	logic signed [COUNT_BITS-1:0] best_q, best_nx, cur, sat_v;
	logic signed [COUNT_BITS:0]   sum;
	logic                  res_valid_q;
	logic [31:0]           res_q;
	logic                  go, is_est, we;
	logic [ADDR_W-1:0]     waddr;
	logic [COUNT_BITS-1:0] wdata;

	assign cur    = rdata_q;
	assign is_est = (op_q.cmd == CMD_EST);
	assign sum    = {cur[COUNT_BITS-1], cur} + (COUNT_BITS+1)'(op_q.delta);

	always_comb begin
		if (sum[COUNT_BITS] != sum[COUNT_BITS-1]) begin
			sat_v = sum[COUNT_BITS] ? {1'b1, {(COUNT_BITS-1){1'b0}}}
			                        : {1'b0, {(COUNT_BITS-1){1'b1}}};
		end else begin
			sat_v = sum[COUNT_BITS-1:0];
		end
		best_nx = ((op_q.row == '0) || (cur < best_q)) ? cur : best_q;
	end

	// The final row of an estimate waits until the result register is free.
	assign go = !(is_est && op_q.last) || !res_valid_q || res_pop;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) state_nx = B_IDLE;
			end
			B_IDLE: begin
				if (!q_empty) state_nx = B_EXEC;
			end
			B_EXEC: begin
				if (go) state_nx = B_IDLE;
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == B_IDLE) && !q_empty;
		clearing  = (state_q == B_CLEAR);
		we        = clearing || ((state_q == B_EXEC) && go && !is_est);
		waddr     = clearing ? clr_q : {op_q.row, op_q.col};
		wdata     = clearing ? '0 : sat_v;
		res_valid = res_valid_q;
		res_value = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == B_CLEAR) clr_q <= clr_q + 1'b1;
			if (res_pop) res_valid_q <= 1'b0;
			if ((state_q == B_EXEC) && go && is_est && op_q.last) res_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) op_q <= q_op;
		if ((state_q == B_EXEC) && go && is_est) begin
			best_q <= best_nx;
			if (op_q.last) res_q <= best_nx[31:0];
		end
	end

	// The counter is read as the operation leaves the queue and held while it waits.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (q_pop) rdata_q <= mem[{q_op.row, q_op.col}];
	end

endmodule
`default_nettype wire

### rtl/count_min_sketch_core.sv
`default_nettype none
// Each row passes the hash front end in order: the two 64-bit multiplies, the modulo
// and one push into the queue, which waits while the queue is full; an estimate result
// shows once the back end has carried out its last row. The front end takes a new beat
// only after it has queued every row of the last one, as the hash and modulo unit is
// shared. Reset: asynchronous, active low; afterward the counter memory is cleared one
// entry a cycle while full stays high.
// ----------------------------------------------------------------------------
// count_min_sketch_core: count-min sketch with four hashed rows of counters
// The front end hashes each beat's key per row; the back end updates or reads
// the counter memory. A queue between them lets both sides stall on their own.
// ----------------------------------------------------------------------------
module count_min_sketch_core import cms_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        command,
	input  wire logic [63:0] key,
	input  wire logic signed [15:0] delta,
	output logic             empty,
	input  wire logic        pop,
	output logic signed [31:0] estimate,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [8:0]  wr_data
);

	logic [8:0] cols_q;
	logic [2:0] rows_q;
	logic [8:0] ncols;
	logic [2:0] nrows;
	logic       front_busy, clearing, start;
	logic       q_push, q_full, q_pop, q_empty;
	op_t        q_in, q_out;
	logic       res_valid, res_pop;
	logic [31:0] res_value;

	// Register writes land directly; out-of-range indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 9'd256;
			rows_q <= 3'd4;
		end else if (wr_en) begin
			case (wr_index)
				REG_COLS: cols_q <= wr_data;
				REG_ROWS: rows_q <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	// A zero count acts as one, and counts above the table size are clamped.
	always_comb begin
		ncols = cols_q;
		if (cols_q == 9'd0) ncols = 9'd1;
		if (cols_q > 9'(COLS)) ncols = 9'(COLS);
		nrows = rows_q;
		if (rows_q == 3'd0) nrows = 3'd1;
		if (rows_q > 3'(ROWS)) nrows = 3'(ROWS);
	end

	// The front end takes a new beat only when it is idle and the clear is done.
	assign full     = front_busy || clearing;
	assign start    = push && !full;
	assign empty    = !res_valid;
	assign res_pop  = pop && res_valid;
	assign estimate = res_value;

	cms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.key    (key),
		.delta  (delta),
		.ncols  (ncols),
		.nrows  (nrows),
		.busy   (front_busy),
		.q_push (q_push),
		.q_op   (q_in),
		.q_full (q_full)
	);

	cms_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.push_op(q_in),
		.full   (q_full),
		.pop    (q_pop),
		.pop_op (q_out),
		.empty  (q_empty)
	);

	cms_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_op     (q_out),
		.q_pop    (q_pop),
		.res_pop  (res_pop),
		.res_valid(res_valid),
		.res_value(res_value),
		.clearing (clearing)
	);

endmodule
`default_nettype wire

### rtl/cms_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cms_checker: port-level checks of the count-min sketch
// Watches the queue-style ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module cms_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        pop,
	input wire logic        empty,
	input wire logic [31:0] estimate
);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("input taken while previous beat still hashing");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(estimate))
		else $error("waiting result changed or vanished");

	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> full)
		else $error("input open before the counter clear");

endmodule

bind count_min_sketch_core cms_checker u_cms_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.push    (push),
	.full    (full),
	.pop     (pop),
	.empty   (empty),
	.estimate(estimate)
);
`default_nettype wire

### tb/count_min_sketch_core_tb.sv
// ----------------------------------------------------------------------------
// count_min_sketch_core_tb: self-checking bench for the count-min sketch core
// Drives adds and estimates through the push/full port and pops estimates
// under random idling. A scoreboard keeps its own counter table, works out
// each estimate from it and compares every popped beat with the oldest one.
// ----------------------------------------------------------------------------
module count_min_sketch_core_tb;
	import cms_pkg::*;

	// Keeps a private copy of the sketch table and the register settings.
	// An accepted add updates the table; an accepted estimate queues the
	// minimum that the block is expected to return.
	class sketch_scoreboard;
		longint signed counts[DEPTH];
		int unsigned   col_setting;
		int unsigned   row_setting;
		logic signed [31:0] pending_estimates[$];
		int unsigned   mismatches;

		function new();
			foreach (counts[i]) counts[i] = 0;
			col_setting = 256;
			row_setting = 4;
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [8:0] value);
			if (index == REG_COLS) col_setting = value;
			else if (index == REG_ROWS) row_setting = value[2:0];
		endfunction

		// splitmix64 finalizer, written out step by step.
		function logic [63:0] mix64(logic [63:0] v);
			v = v + GOLDEN;
			v = (v ^ (v >> SH1)) * MIX1;
			v = (v ^ (v >> SH2)) * MIX2;
			return v ^ (v >> SH3);
		endfunction

		function void note_beat(cmd_t cmd, logic [63:0] k, logic signed [15:0] d);
			int unsigned ncols;
			int unsigned nrows;
			int unsigned col;
			int unsigned slot;
			longint signed lowest;
			longint signed sum;
			logic [63:0] h;
			ncols = (col_setting == 0) ? 1 : (col_setting > COLS ? COLS : col_setting);
			nrows = (row_setting == 0) ? 1 : (row_setting > ROWS ? ROWS : row_setting);
			lowest = 0;
			for (int r = 0; r < nrows; r++) begin
				h = mix64(k + 64'(r) * STRIDE);
				col = 32'(h % 64'(ncols));
				slot = r * COLS + col;
				if (cmd == CMD_EST) begin
					if (r == 0 || counts[slot] < lowest) lowest = counts[slot];
				end else begin
					// Counters clamp at the 32-bit signed limits.
					sum = counts[slot] + d;
					if (sum > 64'sd2147483647) sum = 64'sd2147483647;
					if (sum < -64'sd2147483648) sum = -64'sd2147483648;
					counts[slot] = sum;
				end
			end
			if (cmd == CMD_EST) pending_estimates.push_back(lowest[31:0]);
		endfunction

		function void check_estimate(logic signed [31:0] got);
			logic signed [31:0] want;
			if (pending_estimates.size() == 0) begin
				$error("estimate beat %0d with nothing expected", got);
				mismatches++;
				return;
			end
			want = pending_estimates.pop_front();
			if (got !== want) begin
				$error("estimate: expected %0d, got %0d", want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        command = 1'b0;
	logic [63:0] key = '0;
	logic signed [15:0] delta = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic signed [31:0] estimate;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = '0;
	logic [8:0]  wr_data = '0;

	sketch_scoreboard board;
	int unsigned push_idle_pct;
	int unsigned pop_idle_pct;
	bit          stimulus_done;

	// A small pool of keys so that estimates hit counters that adds touched.
	logic [63:0] key_pool[16];

	count_min_sketch_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.command(command), .key(key), .delta(delta),
		.empty(empty), .pop(pop), .estimate(estimate),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Pushes one beat, with a random idle gap ahead of it, and holds it
	// until the block takes it. The scoreboard notes it at the edge of
	// acceptance.
	task automatic send_beat(cmd_t cmd, logic [63:0] k, logic signed [15:0] d);
		while ($urandom_range(99) < push_idle_pct) @(negedge clk);
		push <= 1'b1;
		command <= cmd;
		key <= k;
		delta <= d;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		board.note_beat(cmd, k, d);
		@(negedge clk);
		push <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every queued estimate has been popped, then lets the back
	// end finish any trailing add before registers change.
	task automatic drain();
		while (board.pending_estimates.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [8:0] value);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= value;
		@(posedge clk);
		board.write_reg(index, value);
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_key();
		if ($urandom_range(3) != 0) return key_pool[$urandom_range(15)];
		return {$urandom(), $urandom()};
	endfunction

	// Deltas lean to the extremes now and then so saturation is reached.
	function automatic logic signed [15:0] rand_delta();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic random_phase(int unsigned beats);
		for (int i = 0; i < beats; i++) begin
			if ($urandom_range(2) == 0) send_beat(CMD_EST, rand_key(), 16'($urandom()));
			else send_beat(CMD_ADD, rand_key(), rand_delta());
		end
	endtask

	// Result side: pops with random stalls and checks each accepted beat.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= pop_idle_pct);
			@(posedge clk);
			if (pop && !empty) board.check_estimate(estimate);
		end
	end

	initial begin
		board = new();
		push_idle_pct = 16;
		pop_idle_pct = 62;
		stimulus_done = 0;
		foreach (key_pool[i]) key_pool[i] = {$urandom(), $urandom()};
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: key extremes, empty-table estimates, extreme deltas in
		// both directions and the command with ignored delta.
		send_beat(CMD_EST, 64'h0, 16'sh0);
		send_beat(CMD_EST, 64'hffff_ffff_ffff_ffff, 16'sh7fff);
		for (int i = 0; i < 4; i++) send_beat(CMD_ADD, 64'h0, 16'sh7fff);
		send_beat(CMD_EST, 64'h0, 16'sh8000);
		send_beat(CMD_ADD, 64'hffff_ffff_ffff_ffff, 16'sh8000);
		send_beat(CMD_ADD, 64'haaaa_5555_aaaa_5555, 16'sh0001);
		send_beat(CMD_EST, 64'hffff_ffff_ffff_ffff, 16'sh0);
		send_beat(CMD_EST, 64'haaaa_5555_aaaa_5555, 16'shffff);
		// Push one row counter toward the positive limit in a single column.
		drain();
		write_reg(REG_COLS, 9'd1);
		write_reg(REG_ROWS, 3'd1);
		for (int i = 0; i < 3; i++) send_beat(CMD_ADD, 64'h1234, 16'sh7fff);
		drain();
		// Positive overflow needs many beats; estimates confirm clamp after
		// the random phase with extreme deltas. Negative side next.
		for (int i = 0; i < 4; i++) send_beat(CMD_ADD, 64'h5555_aaaa_5555_aaaa, 16'sh8000);
		send_beat(CMD_EST, 64'h77, 16'sh0);
		drain();

		// Register corner cases: zero, out-of-range and odd settings.
		write_reg(REG_COLS, 9'd0);
		write_reg(REG_ROWS, 3'd0);
		random_phase(60);
		drain();
		write_reg(REG_COLS, 9'h1ff);
		write_reg(REG_ROWS, 3'd7);
		random_phase(120);
		drain();
		write_reg(REG_COLS, 9'd3);
		write_reg(REG_ROWS, 3'd2);
		random_phase(150);
		drain();
		write_reg(REG_COLS, 9'd256);
		write_reg(REG_ROWS, 3'd4);
		random_phase(170);
		drain();

		push_idle_pct = 62;
		pop_idle_pct = 16;
		write_reg(REG_COLS, 9'd17);
		write_reg(REG_ROWS, 3'd3);
		random_phase(200);
		drain();
		write_reg(REG_COLS, 9'd2);
		write_reg(REG_ROWS, 3'd1);
		random_phase(120);
		drain();

		push_idle_pct = 0;
		pop_idle_pct = 0;
		write_reg(REG_COLS, 9'd255);
		write_reg(REG_ROWS, 3'd4);
		random_phase(260);
		drain();

		if (board.mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	initial begin
		#400000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
rtl/cms_pkg.sv
rtl/cms_front.sv
rtl/cms_queue.sv
rtl/cms_back.sv
rtl/count_min_sketch_core.sv
rtl/cms_checker.sv
tb/count_min_sketch_core_tb.sv
